### rtl/int7_dot_product_macros.svh
// Assertion helpers for the checker file of this block.
// Each macro expects a signal named aclk, and I7DP_ASSERT also aresetn, in the scope of its use.
`ifndef INT7_DOT_PRODUCT_MACROS_SVH
`define INT7_DOT_PRODUCT_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define I7DP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define I7DP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/i7dp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i7dp_pkg;

    // Element and count widths of one request.
    localparam int ELEM_W  = 7;
    localparam int COUNT_W = 4;

    // Score and accumulator widths.
    localparam int SCORE_W = 31;
    localparam int ACC_W   = SCORE_W + 1;
    localparam int OUT_W   = ((SCORE_W + 7) / 8) * 8;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Control handed from the input register to the accumulator.
    typedef struct packed {
        logic valid;
        logic last;
    } acc_ctl_t;

endpackage

`default_nettype wire

### rtl/int7_dot_product.sv
// Channel  Direction  Handshake          Payload
// s_       in         tvalid / tready    tdata: doc, query, lane count; tlast: end of pair
// m_       out        tvalid / tready    tdata: score
//
// One request per cycle is accepted while no closing request waits; every request passes
// an input register, then the lane multipliers and the accumulator sum it combinationally.
// The score of a pair passes the input register and then the result register to m_.
// aresetn clears the running sum and both valid flags.
// A stalled result holds closing requests back, and all requests behind them.
`timescale 1ns / 1ps
`default_nettype none

module int7_dot_product #(
    parameter int LANES = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata fields, low bits first: doc_elems, query_elems, lane_count, zero fill
    input  wire logic [((2*LANES*i7dp_pkg::ELEM_W+i7dp_pkg::COUNT_W+7)/8)*8-1:0] s_tdata,
    input  wire logic                                 s_tlast,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // m_tdata fields, low bits first: score, zero fill
    output logic      [i7dp_pkg::OUT_W-1:0]           m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready
);
    import i7dp_pkg::*;

    localparam int ELEMS_W = LANES * ELEM_W;
    localparam int PSUM_W  = 2 * ELEM_W + $clog2(LANES + 1);

    logic [ELEMS_W-1:0] doc_reg, doc_next;
    logic [ELEMS_W-1:0] query_reg, query_next;
    count_t             count_reg, count_next;
    logic               last_reg, last_next;
    logic               valid_reg, valid_next;

    acc_ctl_t           ctl;
    logic [PSUM_W-1:0]  psum;
    logic               take;
    score_t             score;

    // Input register: refills whenever it is empty or its request moves on.
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        doc_next   = doc_reg;
        query_next = query_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            doc_next   = s_tdata[ELEMS_W-1:0];
            query_next = s_tdata[2*ELEMS_W-1:ELEMS_W];
            count_next = s_tdata[2*ELEMS_W +: COUNT_W];
            last_next  = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        doc_reg   <= doc_next;
        query_reg <= query_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    // Lane products summed under the lane count.
    i7dp_lanes #(
        .LANES  (LANES),
        .PSUM_W (PSUM_W)
    ) u_lanes (
        .doc   (doc_reg),
        .query (query_reg),
        .count (count_reg),
        .psum  (psum)
    );

    assign ctl.valid = valid_reg;
    assign ctl.last  = last_reg;

    // Running sum and result register.
    i7dp_accum #(
        .PSUM_W (PSUM_W)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .psum        (psum),
        .take        (take),
        .score       (score),
        .score_valid (m_tvalid),
        .score_ready (m_tready)
    );

    assign m_tdata = OUT_W'(score);

endmodule

`default_nettype wire

### rtl/i7dp_lanes.sv
`timescale 1ns / 1ps
`default_nettype none

module i7dp_lanes #(
    parameter int LANES  = 8,
    parameter int PSUM_W = 18
) (
    input  wire logic [LANES*i7dp_pkg::ELEM_W-1:0] doc,
    input  wire logic [LANES*i7dp_pkg::ELEM_W-1:0] query,
    input  wire i7dp_pkg::count_t                  count,
    output logic      [PSUM_W-1:0]                 psum
);
    import i7dp_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;

    logic [PROD_W-1:0] prod [LANES];

    // One small multiplier per lane.
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        assign prod[k] = doc[k*ELEM_W +: ELEM_W] * query[k*ELEM_W +: ELEM_W];
    end

    // Sum the lanes below the valid count; a count above LANES enables them all.
    always_comb begin
        psum = '0;
        for (int k = 0; k < LANES; k++) begin
            if (COUNT_W'(k) < count) begin
                psum = psum + PSUM_W'(prod[k]);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/i7dp_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module i7dp_accum #(
    parameter int PSUM_W = 18
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire i7dp_pkg::acc_ctl_t   ctl,
    input  wire logic [PSUM_W-1:0]    psum,
    output logic                      take,
    output i7dp_pkg::score_t          score,
    output logic                      score_valid,
    input  wire logic                 score_ready
);
    import i7dp_pkg::*;

    score_t            running_reg, running_next;
    score_t            score_reg, score_next;
    logic              out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]  sum_wide;
    score_t            sum_sat;

    // A closing request needs the result register free or draining this cycle.
    assign take = ctl.valid && (!ctl.last || !out_valid_reg || score_ready);

    // Accumulate with clamping at the largest score.
    assign sum_wide = {1'b0, running_reg} + ACC_W'(psum);
    assign sum_sat  = sum_wide[ACC_W-1] ? SCORE_MAX : sum_wide[SCORE_W-1:0];

    always_comb begin
        running_next   = running_reg;
        score_next     = score_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && score_ready) begin
            out_valid_next = 1'b0;
        end
        if (take) begin
            if (ctl.last) begin
                running_next   = '0;
                score_next     = sum_sat;
                out_valid_next = 1'b1;
            end else begin
                running_next = sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The score itself needs no reset.
    always_ff @(posedge aclk) begin
        score_reg <= score_next;
    end

    assign score       = score_reg;
    assign score_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/i7dp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "int7_dot_product_macros.svh"

module i7dp_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       s_tlast,
    input wire logic [i7dp_pkg::OUT_W-1:0] m_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready
);

    // No result survives a reset.
    `I7DP_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result keeps its value.
    `I7DP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // A taken closing request is followed by a valid score.
    `I7DP_ASSERT(a_last_gives_score, s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid, "closing request produced no score")

    // A fresh score only follows a closing request.
    `I7DP_ASSERT(a_score_needs_last, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2), "score without closing request")

endmodule

bind int7_dot_product i7dp_checker u_i7dp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
